@@ design/assert_macros.svh @@
// Assertion macros shared by the height unit RTL.
// Depends on nothing; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GBH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GBH_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GBH_ASSERT(label, clk, rst, prop, msg)
`define GBH_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ design/gbh_pkg.sv @@
// Shared types and constants for the grid bilinear height unit.
// No dependencies.
`default_nettype none

package gbh_pkg;

   localparam int IDX_W       = 10;  // widest lattice index over the supported grid sides
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] CSR_RIGIDITY = 2'd0;
   localparam logic [1:0] CSR_GAIN     = 2'd1;
   localparam logic [1:0] CSR_COLS     = 2'd2;
   localparam logic [1:0] CSR_ROWS     = 2'd3;

   localparam logic [15:0]        RIGIDITY_RST = 16'd3277;
   localparam logic signed [15:0] GAIN_RST     = 16'sd2304;
   localparam logic [7:0]         COLS_RST     = 8'd128;
   localparam logic [7:0]         ROWS_RST     = 8'd128;

   typedef struct packed {
      logic [15:0]        rigidity;
      logic signed [15:0] gain;
      logic [7:0]         cols;
      logic [7:0]         rows;
   } gbh_cfg_type;

   typedef struct packed {
      logic               is_query;
      logic               write_en;
      logic               oog;
      logic [IDX_W-1:0]   col;
      logic [IDX_W-1:0]   row;
      logic signed [15:0] value;
      logic [15:0]        frac_x;
      logic [15:0]        frac_y;
   } gbh_item_type;

endpackage

`default_nettype wire

@@ design/grid_bilinear_height_unit.sv @@
// Grid bilinear height unit. Load requests write one Q1.14 lattice value;
// query requests return one Q15.8 height, bilinearly blended from the four
// corners of the cell under the scaled position and multiplied by the gain,
// with out_of_grid set (and height zero) when a corner falls outside the
// configured grid. Loads return nothing. One request is taken per cycle while
// req_stall is low; a query result passes the front register, the queue and
// the back-end stages. The rate is set by the lattice store, split by column
// and row parity into four banks with one write and one read port each, so
// all four corners are read in a single cycle. A four-entry queue sits between
// the front and back ends. Entries must be loaded before a query reads them.
// Configuration must be written only while idle; the block does not enforce
// it. csr_ready is always high. Uses gbh_pkg, gbh_* modules, assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module grid_bilinear_height_unit import gbh_pkg::*; #(
   parameter int GRID_SIDE = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic [6:0]         req_cell_col,
   input  wire logic [6:0]         req_cell_row,
   input  wire logic signed [15:0] req_cell_value,
   input  wire logic [23:0]        req_pos_x,
   input  wire logic [23:0]        req_pos_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_height,
   output logic                    rsp_out_of_grid
);

   gbh_cfg_type  cfg_ff, cfg_in;
   logic         q_push, q_full, q_pop, q_head_valid;
   gbh_item_type q_push_item, q_head_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RIGIDITY: cfg_in.rigidity = csr_data;
            CSR_GAIN:     cfg_in.gain     = csr_data;
            CSR_COLS:     cfg_in.cols     = csr_data[7:0];
            CSR_ROWS:     cfg_in.rows     = csr_data[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rigidity <= RIGIDITY_RST;
         cfg_ff.gain     <= GAIN_RST;
         cfg_ff.cols     <= COLS_RST;
         cfg_ff.rows     <= ROWS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gbh_front #(
      .GRID_SIDE (GRID_SIDE)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_cell_col   (req_cell_col),
      .req_cell_row   (req_cell_row),
      .req_cell_value (req_cell_value),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_item         (q_push_item)
   );

   gbh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   gbh_back #(
      .GRID_SIDE (GRID_SIDE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .gain            (cfg_ff.gain),
      .head_valid      (q_head_valid),
      .head_item       (q_head_item),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_height      (rsp_height),
      .rsp_out_of_grid (rsp_out_of_grid)
   );

   `GBH_ASSERT(a_queue_no_overflow, clock, reset, !(q_push && q_full), "push into full queue")
   `GBH_ASSERT(a_queue_no_underflow, clock, reset, q_pop |-> q_head_valid, "pop from empty queue")
   `GBH_ASSERT(a_oog_zero_height, clock, reset, (rsp_valid && rsp_out_of_grid) |-> (rsp_height == '0), "out of grid result with nonzero height")

endmodule

`default_nettype wire

@@ design/gbh_front.sv @@
// Front end: takes requests, scales query positions, splits cell and
// fraction, checks grid bounds and pushes work items. Uses gbh_pkg.
`default_nettype none

module gbh_front import gbh_pkg::*; #(
   parameter int GRID_SIDE = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire gbh_cfg_type        cfg,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic [6:0]         req_cell_col,
   input  wire logic [6:0]         req_cell_row,
   input  wire logic signed [15:0] req_cell_value,
   input  wire logic [23:0]        req_pos_x,
   input  wire logic [23:0]        req_pos_y,
   input  wire logic               q_full,
   output logic                    q_push,
   output gbh_item_type            q_item
);

   logic               f_valid_ff, f_valid_in;
   logic               f_cmd_ff, f_cmd_in;
   logic [6:0]         f_col_ff, f_col_in;
   logic [6:0]         f_row_ff, f_row_in;
   logic signed [15:0] f_value_ff, f_value_in;
   logic [39:0]        f_sx_ff, f_sx_in;
   logic [39:0]        f_sy_ff, f_sy_in;

   logic        advance;
   logic [15:0] cell_x, cell_y;
   logic [16:0] cols_eff, rows_eff;
   logic        is_query, oog, load_ok;

   assign advance   = !f_valid_ff || !q_full;
   assign req_stall = f_valid_ff && q_full;
   assign q_push    = f_valid_ff && !q_full;

   always_comb begin
      f_valid_in = advance ? req_valid : f_valid_ff;
      f_cmd_in   = f_cmd_ff;
      f_col_in   = f_col_ff;
      f_row_in   = f_row_ff;
      f_value_in = f_value_ff;
      f_sx_in    = f_sx_ff;
      f_sy_in    = f_sy_ff;
      if (advance && req_valid) begin
         f_cmd_in   = req_command;
         f_col_in   = req_cell_col;
         f_row_in   = req_cell_row;
         f_value_in = req_cell_value;
         f_sx_in    = 40'(req_pos_x) * 40'(cfg.rigidity);
         f_sy_in    = 40'(req_pos_y) * 40'(cfg.rigidity);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      f_cmd_ff   <= f_cmd_in;
      f_col_ff   <= f_col_in;
      f_row_ff   <= f_row_in;
      f_value_ff <= f_value_in;
      f_sx_ff    <= f_sx_in;
      f_sy_ff    <= f_sy_in;
   end

   // Q16.24 scaled position: integer part is the cell, bits 23..8 the fraction
   assign cell_x = f_sx_ff[39:24];
   assign cell_y = f_sy_ff[39:24];

   assign cols_eff = (17'(cfg.cols) < 17'(GRID_SIDE)) ? 17'(cfg.cols) : 17'(GRID_SIDE);
   assign rows_eff = (17'(cfg.rows) < 17'(GRID_SIDE)) ? 17'(cfg.rows) : 17'(GRID_SIDE);

   assign is_query = (f_cmd_ff == CMD_QUERY);
   assign oog      = ((17'(cell_x) + 17'd1) >= cols_eff) || ((17'(cell_y) + 17'd1) >= rows_eff);
   assign load_ok  = (32'(f_col_ff) < 32'(GRID_SIDE)) && (32'(f_row_ff) < 32'(GRID_SIDE));

   always_comb begin
      q_item.is_query = is_query;
      q_item.write_en = !is_query && load_ok;
      q_item.oog      = is_query && oog;
      q_item.col      = is_query ? cell_x[IDX_W-1:0] : IDX_W'(f_col_ff);
      q_item.row      = is_query ? cell_y[IDX_W-1:0] : IDX_W'(f_row_ff);
      q_item.value    = f_value_ff;
      q_item.frac_x   = f_sx_ff[23:8];
      q_item.frac_y   = f_sy_ff[23:8];
   end

endmodule

`default_nettype wire

@@ design/gbh_queue.sv @@
// Short in-order work queue between the front and back ends.
// Uses gbh_pkg for the item type and depth.
`default_nettype none

module gbh_queue import gbh_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire gbh_item_type push_item,
   output logic              full,
   input  wire logic         pop,
   output logic              head_valid,
   output gbh_item_type      head_item
);

   gbh_item_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ design/gbh_back.sv @@
// Back end: lattice store in four parity banks, bilinear blend, gain and
// saturation, and the result register. Uses gbh_pkg.
`default_nettype none

module gbh_back import gbh_pkg::*; #(
   parameter int GRID_SIDE = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [15:0] gain,
   input  wire logic               head_valid,
   input  wire gbh_item_type       head_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_height,
   output logic                    rsp_out_of_grid
);

   localparam int IW         = $clog2(GRID_SIDE);
   localparam int HALF       = (GRID_SIDE + 1) / 2;
   localparam int BANK_DEPTH = HALF * HALF;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   function automatic logic [AW-1:0] bank_addr(input logic [IW-1:0] c, input logic [IW-1:0] r);
      bank_addr = AW'(32'(c >> 1) * HALF + 32'(r >> 1));
   endfunction

   logic          advance;
   logic [IW-1:0] col, row, col_nxt, row_nxt;
   logic [AW-1:0] wr_addr;
   logic signed [15:0] bank_rd [4];

   assign advance = !rsp_valid || !rsp_stall;
   assign pop     = head_valid && advance;

   assign col     = head_item.col[IW-1:0];
   assign row     = head_item.row[IW-1:0];
   assign col_nxt = col + 1'b1;
   assign row_nxt = row + 1'b1;
   assign wr_addr = bank_addr(col, row);

   // Bank k holds entries with column parity k[1] and row parity k[0], so the
   // four corners of a cell always fall in four different banks.
   for (genvar k = 0; k < 4; k++) begin : g_bank
      localparam logic BC = 1'((k >> 1) & 1);
      localparam logic BR = 1'(k & 1);

      logic signed [15:0] lattice_mem [BANK_DEPTH];
      logic signed [15:0] rd_data_ff;
      logic [IW-1:0]      col_sel, row_sel;
      logic [AW-1:0]      rd_addr;
      logic               wr_hit;

      assign col_sel = (col[0] == BC) ? col : col_nxt;
      assign row_sel = (row[0] == BR) ? row : row_nxt;
      assign rd_addr = bank_addr(col_sel, row_sel);
      assign wr_hit  = pop && head_item.write_en && (col[0] == BC) && (row[0] == BR);

      always_ff @(posedge clock) begin
         if (advance) begin
            if (wr_hit) begin
               lattice_mem[wr_addr] <= head_item.value;
            end
            rd_data_ff <= lattice_mem[rd_addr];
         end
      end

      assign bank_rd[k] = rd_data_ff;
   end

   // stage 1: corner reads
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_oog_ff, s1_pc_ff, s1_pr_ff;
   logic [15:0] s1_fx_ff, s1_fy_ff;

   assign s1_valid_in = head_valid && head_item.is_query;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
      if (advance) begin
         s1_oog_ff <= head_item.oog;
         s1_pc_ff  <= col[0];
         s1_pr_ff  <= row[0];
         s1_fx_ff  <= head_item.frac_x;
         s1_fy_ff  <= head_item.frac_y;
      end
   end

   // stage 2: blend along y
   logic signed [15:0] r00, r01, r10, r11, v00, v01, v10, v11;
   logic signed [16:0] diff_a, diff_b, fy_s;
   logic signed [33:0] prod_a, prod_b, base_a, base_b, sum_a, sum_b;
   logic signed [31:0] s2_a_ff, s2_a_in, s2_b_ff, s2_b_in;
   logic               s2_valid_ff, s2_oog_ff;
   logic [15:0]        s2_fx_ff;

   always_comb begin
      r00 = s1_pr_ff ? bank_rd[1] : bank_rd[0];
      r01 = s1_pr_ff ? bank_rd[0] : bank_rd[1];
      r10 = s1_pr_ff ? bank_rd[3] : bank_rd[2];
      r11 = s1_pr_ff ? bank_rd[2] : bank_rd[3];
      v00 = s1_pc_ff ? r10 : r00;
      v01 = s1_pc_ff ? r11 : r01;
      v10 = s1_pc_ff ? r00 : r10;
      v11 = s1_pc_ff ? r01 : r11;
      fy_s    = $signed({1'b0, s1_fy_ff});
      diff_a  = 17'(v01) - 17'(v00);
      diff_b  = 17'(v11) - 17'(v10);
      prod_a  = fy_s * diff_a;
      prod_b  = fy_s * diff_b;
      base_a  = 34'(v00) <<< 16;
      base_b  = 34'(v10) <<< 16;
      sum_a   = base_a + prod_a;
      sum_b   = base_b + prod_b;
      s2_a_in = sum_a[31:0];
      s2_b_in = sum_b[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_oog_ff <= s1_oog_ff;
         s2_fx_ff  <= s1_fx_ff;
         s2_a_ff   <= s2_a_in;
         s2_b_ff   <= s2_b_in;
      end
   end

   // stage 3: blend along x, Q.46
   logic signed [32:0] diff_x;
   logic signed [16:0] fx_s;
   logic signed [49:0] prod_x, base_x, sum_x;
   logic signed [47:0] s3_blend_ff, s3_blend_in;
   logic               s3_valid_ff, s3_oog_ff;

   always_comb begin
      fx_s        = $signed({1'b0, s2_fx_ff});
      diff_x      = 33'(s2_b_ff) - 33'(s2_a_ff);
      prod_x      = fx_s * diff_x;
      base_x      = 50'(s2_a_ff) <<< 16;
      sum_x       = base_x + prod_x;
      s3_blend_in = sum_x[47:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_oog_ff   <= s2_oog_ff;
         s3_blend_ff <= s3_blend_in;
      end
   end

   // stage 4: round to Q.22, apply gain
   logic signed [47:0] rnd_blend, shf_blend;
   logic signed [23:0] blend_q22;
   logic signed [39:0] s4_prod_ff, s4_prod_in;
   logic               s4_valid_ff, s4_oog_ff;

   always_comb begin
      rnd_blend  = s3_blend_ff + 48'sd8388608;
      shf_blend  = rnd_blend >>> 24;
      blend_q22  = shf_blend[23:0];
      s4_prod_in = blend_q22 * gain;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_oog_ff  <= s3_oog_ff;
         s4_prod_ff <= s4_prod_in;
      end
   end

   // stage 5: round to Q.8, saturate, result register
   logic signed [40:0] rnd_h, shf_h;
   logic signed [23:0] height_sat;
   logic               out_valid_ff, out_oog_ff;
   logic signed [23:0] out_height_ff, out_height_in;

   always_comb begin
      rnd_h = 41'(s4_prod_ff) + 41'sd2097152;
      shf_h = rnd_h >>> 22;
      if (shf_h > 41'sd8388607) begin
         height_sat = 24'sh7FFFFF;
      end else if (shf_h < -41'sd8388608) begin
         height_sat = 24'sh800000;
      end else begin
         height_sat = shf_h[23:0];
      end
      out_height_in = s4_oog_ff ? '0 : height_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         out_oog_ff    <= s4_oog_ff;
         out_height_ff <= out_height_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_height      = out_height_ff;
   assign rsp_out_of_grid = out_oog_ff;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for grid_bilinear_height_unit: lattice loads and height
// queries, checked against an in-bench height predictor across several CSR settings.
// Depends on gbh_pkg and the grid_bilinear_height_unit RTL.
module tb;
   import gbh_pkg::*;

   localparam int SIDE         = 128;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_LEN     = 80;
   localparam int NUM_SEGMENTS = 8;
   localparam int NUM_DIRECTED = 21;

   typedef struct packed {
      logic        cmd;
      logic [6:0]  col;
      logic [6:0]  row;
      logic [15:0] value;
      logic [23:0] px;
      logic [23:0] py;
   } request_type;

   typedef struct packed {
      logic signed [23:0] height;
      logic               oog;
   } height_result_type;

   typedef struct packed {
      request_type req;
      logic        typed;
      logic [23:0] height;
      logic        oog;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = CSR_RIGIDITY;
   logic [15:0]        csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_command = CMD_LOAD;
   logic [6:0]         req_cell_col = '0;
   logic [6:0]         req_cell_row = '0;
   logic signed [15:0] req_cell_value = '0;
   logic [23:0]        req_pos_x = '0;
   logic [23:0]        req_pos_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_height;
   logic               rsp_out_of_grid;

   grid_bilinear_height_unit dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_cell_col(req_cell_col),
      .req_cell_row(req_cell_row),
      .req_cell_value(req_cell_value),
      .req_pos_x(req_pos_x),
      .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_height(rsp_height),
      .rsp_out_of_grid(rsp_out_of_grid)
   );

   // predictor state
   logic signed [15:0] lattice_copy [SIDE*SIDE];
   bit                 lattice_written [SIDE*SIDE];
   logic [15:0]        cfg_rigidity = RIGIDITY_RST;
   logic signed [15:0] cfg_gain = GAIN_RST;
   logic [7:0]         cfg_cols = COLS_RST;
   logic [7:0]         cfg_rows = ROWS_RST;

   height_result_type pending_heights [$];

   int errors = 0;
   int heights_checked = 0;
   int loads_sent = 0;
   int queries_sent = 0;
   int input_stall_cycles = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int holdoffs_requested = 0;
   int holdoffs_served = 0;
   int hold_left = 0;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{CMD_LOAD, 7'd0, 7'd0, 16'sd16384, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_LOAD, 7'd0, 7'd1, -16'sd16384, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_LOAD, 7'd1, 7'd0, 16'sd0, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_LOAD, 7'd1, 7'd1, 16'sd16383, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd0, 24'd0}, 1'b1, 24'd2304, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, 24'd0, 1'b1},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd0, 24'hFFFFFF}, 1'b1, 24'd0, 1'b1},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'hFFFFFF, 24'd0}, 1'b1, 24'd0, 1'b1},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd2560, 24'd2560}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd5119, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd0, 24'd5119}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_LOAD, 7'd126, 7'd126, 16'h8000, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_LOAD, 7'd126, 7'd127, 16'h7FFF, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_LOAD, 7'd127, 7'd126, 16'hFFFF, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_LOAD, 7'd127, 7'd127, 16'sd16384, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd645081, 24'd645081}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd650200, 24'd650200}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd650201, 24'd650200}, 1'b1, 24'd0, 1'b1},
      '{'{CMD_LOAD, 7'd0, 7'd0, 16'sd0, 24'd0, 24'd0}, 1'b0, 24'd0, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd0, 24'd0}, 1'b1, 24'd0, 1'b0},
      '{'{CMD_QUERY, 7'd0, 7'd0, 16'd0, 24'd1, 24'd1}, 1'b0, 24'd0, 1'b0}
   };

   logic [15:0] seg_rigidity [NUM_SEGMENTS] =
      '{16'd65535, 16'd0, 16'd3277, 16'd1, 16'd12000, 16'd0, 16'd20000, 16'd0};
   logic [15:0] seg_gain [NUM_SEGMENTS] =
      '{16'h7FFF, 16'h8000, 16'd2304, 16'd0, 16'hFF00, 16'd0, 16'd1234, 16'd0};
   logic [7:0]  seg_cols [NUM_SEGMENTS] =
      '{8'd128, 8'd2, 8'd128, 8'd1, 8'd17, 8'd255, 8'd128, 8'd0};
   logic [7:0]  seg_rows [NUM_SEGMENTS] =
      '{8'd128, 8'd2, 8'd128, 8'd0, 8'd9, 8'd200, 8'd128, 8'd0};
   int          seg_items [NUM_SEGMENTS] = '{180, 170, 180, 60, 170, 170, 190, 180};

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("cycle limit reached with %0d heights pending", pending_heights.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stall, plus a long hold-off on request
   always @(negedge clock) begin
      if (holdoffs_served != holdoffs_requested) begin
         hold_left = HOLD_LEN;
         holdoffs_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      height_result_type exp_res;
      if (!reset && req_valid && req_stall)
         input_stall_cycles++;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_heights.size() == 0) begin
            $error("result with no pending query: height %0d out_of_grid %0d",
                   rsp_height, rsp_out_of_grid);
            errors++;
         end else begin
            exp_res = pending_heights.pop_front();
            heights_checked++;
            if (rsp_height !== exp_res.height) begin
               $error("height: expected %0d, actual %0d", exp_res.height, rsp_height);
               errors++;
            end
            if (rsp_out_of_grid !== exp_res.oog) begin
               $error("out_of_grid: expected %0d, actual %0d", exp_res.oog, rsp_out_of_grid);
               errors++;
            end
         end
      end
   end

   function automatic int eff_size(input logic [7:0] n);
      return (n < SIDE) ? int'(n) : SIDE;
   endfunction

   function automatic bit locate(input logic [23:0] px, input logic [23:0] py,
                                 output int cx, output int cy,
                                 output longint fx, output longint fy);
      logic [63:0] sx;
      logic [63:0] sy;
      sx = {40'd0, px} * {48'd0, cfg_rigidity};
      sy = {40'd0, py} * {48'd0, cfg_rigidity};
      cx = int'(sx >> 24);
      cy = int'(sy >> 24);
      fx = longint'((sx >> 8) & 64'hFFFF);
      fy = longint'((sy >> 8) & 64'hFFFF);
      return (cx + 1 < eff_size(cfg_cols)) && (cy + 1 < eff_size(cfg_rows));
   endfunction

   function automatic height_result_type predict_height(input logic [23:0] px,
                                                        input logic [23:0] py);
      int cx, cy;
      longint fx, fy, v00, v01, v10, v11, a, b, blend, h;
      height_result_type r;
      if (!locate(px, py, cx, cy, fx, fy)) begin
         r.height = '0;
         r.oog = 1'b1;
         return r;
      end
      v00 = lattice_copy[cx*SIDE + cy];
      v01 = lattice_copy[cx*SIDE + cy + 1];
      v10 = lattice_copy[(cx+1)*SIDE + cy];
      v11 = lattice_copy[(cx+1)*SIDE + cy + 1];
      a = v00 * 65536 + fy * (v01 - v00);
      b = v10 * 65536 + fy * (v11 - v10);
      blend = a * 65536 + fx * (b - a);
      blend = (blend + (longint'(1) << 23)) >>> 24;
      h = (blend * cfg_gain + (longint'(1) << 21)) >>> 22;
      if (h > 8388607)
         h = 8388607;
      if (h < -8388608)
         h = -8388608;
      r.height = h[23:0];
      r.oog = 1'b0;
      return r;
   endfunction

   function automatic logic [15:0] lattice_value();
      if ($urandom_range(9) == 0)
         return 16'($urandom);
      return 16'(int'($urandom_range(32768)) - 16384);
   endfunction

   function automatic request_type random_request(input logic cmd);
      request_type r;
      r.cmd = cmd;
      r.col = 7'($urandom);
      r.row = 7'($urandom);
      r.value = lattice_value();
      r.px = 24'($urandom);
      r.py = 24'($urandom);
      return r;
   endfunction

   // position whose scaled cell index is c, when one exists
   function automatic logic [23:0] pos_in_cell(input int c);
      logic [63:0] lo, hi, rig;
      rig = {48'd0, cfg_rigidity};
      if (rig == 0)
         return 24'($urandom);
      lo = ((64'(c) << 24) + rig - 1) / rig;
      hi = ((64'(c + 1) << 24) + rig - 1) / rig - 1;
      if (lo > 64'hFFFFFF)
         return 24'($urandom);
      if (hi > 64'hFFFFFF)
         hi = 64'hFFFFFF;
      case ($urandom_range(3))
         0: return 24'(lo);
         1: return 24'(hi);
         default: return 24'(lo + {$urandom, $urandom} % (hi - lo + 1));
      endcase
   endfunction

   task automatic transfer(input request_type req, input bit typed,
                           input height_result_type typed_res);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= req.cmd;
      req_cell_col <= req.col;
      req_cell_row <= req.row;
      req_cell_value <= req.value;
      req_pos_x <= req.px;
      req_pos_y <= req.py;
      do @(posedge clock); while (req_stall);
      if (req.cmd == CMD_LOAD) begin
         lattice_copy[req.col*SIDE + req.row] = req.value;
         lattice_written[req.col*SIDE + req.row] = 1'b1;
         loads_sent++;
      end else begin
         pending_heights.push_back(typed ? typed_res : predict_height(req.px, req.py));
         queries_sent++;
      end
   endtask

   // loads any unwritten corner first, so no query reads an empty entry
   task automatic query(input request_type req, input bit typed,
                        input height_result_type typed_res);
      int cx, cy;
      longint fx, fy;
      request_type ld;
      if (locate(req.px, req.py, cx, cy, fx, fy)) begin
         for (int dc = 0; dc < 2; dc++) begin
            for (int dr = 0; dr < 2; dr++) begin
               if (!lattice_written[(cx+dc)*SIDE + cy + dr]) begin
                  ld = random_request(CMD_LOAD);
                  ld.col = 7'(cx + dc);
                  ld.row = 7'(cy + dr);
                  transfer(ld, 1'b0, '0);
               end
            end
         end
      end
      transfer(req, typed, typed_res);
   endtask

   task automatic cell_sequence();
      int ce, re, cx, cy, nq;
      request_type r;
      ce = eff_size(cfg_cols);
      re = eff_size(cfg_rows);
      cx = ($urandom_range(7) == 0) ? ce - 1 : int'($urandom_range(ce > 2 ? ce - 2 : 0));
      cy = ($urandom_range(7) == 0) ? re - 1 : int'($urandom_range(re > 2 ? re - 2 : 0));
      if (cx < 0) cx = 0;
      if (cx > 126) cx = 126;
      if (cy < 0) cy = 0;
      if (cy > 126) cy = 126;
      for (int dc = 0; dc < 2; dc++) begin
         for (int dr = 0; dr < 2; dr++) begin
            r = random_request(CMD_LOAD);
            r.col = 7'(cx + dc);
            r.row = 7'(cy + dr);
            transfer(r, 1'b0, '0);
         end
      end
      nq = $urandom_range(4, 1);
      repeat (nq) begin
         r = random_request(CMD_QUERY);
         r.px = pos_in_cell(cx);
         r.py = pos_in_cell(cy);
         query(r, 1'b0, '0);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RIGIDITY: cfg_rigidity = data;
         CSR_GAIN:     cfg_gain = data;
         CSR_COLS:     cfg_cols = data[7:0];
         CSR_ROWS:     cfg_rows = data[7:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_heights.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      height_result_type typed_res;
      request_type r;
      logic [15:0] rig, gain;
      logic [7:0] cols, rows;
      int target, pick;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         typed_res.height = directed_rows[i].height;
         typed_res.oog = directed_rows[i].oog;
         if (directed_rows[i].req.cmd == CMD_LOAD)
            transfer(directed_rows[i].req, 1'b0, '0);
         else
            query(directed_rows[i].req, directed_rows[i].typed, typed_res);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      wait_idle();

      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         if (seg < 3) begin
            send_idle_pct = 26;
            recv_idle_pct = 88;
         end else if (seg < 6) begin
            send_idle_pct = 88;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         rig = seg_rigidity[seg];
         gain = seg_gain[seg];
         cols = seg_cols[seg];
         rows = seg_rows[seg];
         if (seg == 5) begin
            rig = 16'($urandom);
            gain = 16'($urandom);
         end
         if (seg == 7) begin
            rig = 16'($urandom_range(65535, 256));
            gain = 16'($urandom);
            cols = 8'($urandom_range(128, 2));
            rows = 8'($urandom_range(128, 2));
         end
         write_csr(CSR_RIGIDITY, rig);
         write_csr(CSR_GAIN, gain);
         write_csr(CSR_COLS, {8'd0, cols});
         write_csr(CSR_ROWS, {8'd0, rows});
         @(negedge clock);
         csr_valid <= 1'b0;

         if (seg == 6)
            holdoffs_requested++;
         target = loads_sent + queries_sent + seg_items[seg];
         while (loads_sent + queries_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
               cell_sequence();
            end else if (pick < 75) begin
               r = random_request(CMD_QUERY);
               r.px = pos_in_cell($urandom_range(eff_size(cfg_cols)));
               r.py = pos_in_cell($urandom_range(eff_size(cfg_rows)));
               query(r, 1'b0, '0);
            end else if (pick < 88) begin
               transfer(random_request(CMD_LOAD), 1'b0, '0);
            end else begin
               query(random_request(CMD_QUERY), 1'b0, '0);
            end
         end
         @(negedge clock);
         req_valid <= 1'b0;
         wait_idle();
      end

      $display("Checked %0d heights from %0d queries and %0d lattice loads over %0d CSR settings.",
               heights_checked, queries_sent, loads_sent, NUM_SEGMENTS + 1);
      $display("Request input stalled %0d cycles; %0d errors.", input_stall_cycles, errors);
      if (errors == 0 && pending_heights.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
